[rtl/core/hog_pkg.sv]
package hog_pkg;

  // Direction codes
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  // Item kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_REQ  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_FULLSCALE = 2'd0;
  localparam logic [1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_TRIPTICKS = 2'd2;

  // Configuration reset values
  localparam logic [12:0] FULLSCALE_RST = 13'd5000;
  localparam logic [10:0] THRESHOLD_RST = 11'd250;
  localparam logic [15:0] TRIPTICKS_RST = 16'd500;

  // floor(x/1023) for x < 2^23: (x * ceil(2^33/1023)) >> 33
  localparam int unsigned MV_SHIFT = 33;
  localparam logic [23:0] MV_RECIP = 24'd8396809;
  // floor(y/14) for y < 2^16: (y * ceil(2^20/14)) >> 20
  localparam int unsigned MA_SHIFT = 20;
  localparam logic [16:0] MA_RECIP = 17'd74899;

  // Saturation limits
  localparam logic [14:0] SUM_MAX  = 15'h7FFF;
  localparam logic [10:0] FILT_MAX = 11'h7FF;

  typedef struct packed {
    logic       kind;
    logic [9:0] adc_sample;
    logic [1:0] requested_direction;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  requested_direction;
    logic [11:0] sample_ma;
  } scaled_t;

  // Packed so that drive_a sits in bit 0
  typedef struct packed {
    logic [10:0] filtered_ma;
    logic        fault_flag;
    logic [1:0]  direction_now;
    logic        drive_b;
    logic        drive_a;
  } result_t;

endpackage

[rtl/core/hog_scale.sv]
module hog_scale (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hog_pkg::in_item_t in_item_i,
  input  logic [12:0]       fullscale_mv_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hog_pkg::scaled_t  out_item_o
);

  // Stage 1: input register
  logic              v1_q;
  hog_pkg::in_item_t s1_q;
  // Stage 2: adc * fullscale
  logic              v2_q;
  logic              s2_kind_q;
  logic [1:0]        s2_dir_q;
  logic [22:0]       s2_prod_q;
  // Stage 3: millivolts
  logic              v3_q;
  logic              s3_kind_q;
  logic [1:0]        s3_dir_q;
  logic [12:0]       s3_mv_q;
  // Stage 4: milliamps
  logic              v4_q;
  hog_pkg::scaled_t  s4_q;

  logic        adv1, adv2, adv3, adv4;
  logic [22:0] raw_prod;
  logic [46:0] mv_prod;
  logic [15:0] mv_x5;
  logic [32:0] ma_prod;

  assign adv4 = !v4_q || out_ready_i;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign in_ready_o  = adv1;
  assign out_valid_o = v4_q;
  assign out_item_o  = s4_q;

  assign raw_prod = 23'(s1_q.adc_sample) * 23'(fullscale_mv_i);
  assign mv_prod  = 47'(s2_prod_q) * 47'(hog_pkg::MV_RECIP);
  assign mv_x5    = 16'({s3_mv_q, 2'b00}) + 16'(s3_mv_q);
  assign ma_prod  = 33'(mv_x5) * 33'(hog_pkg::MA_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      s1_q <= in_item_i;
    end
    if (adv2 && v1_q) begin
      s2_kind_q <= s1_q.kind;
      s2_dir_q  <= s1_q.requested_direction;
      s2_prod_q <= raw_prod;
    end
    if (adv3 && v2_q) begin
      s3_kind_q <= s2_kind_q;
      s3_dir_q  <= s2_dir_q;
      s3_mv_q   <= mv_prod[hog_pkg::MV_SHIFT +: 13];
    end
    if (adv4 && v3_q) begin
      s4_q.kind                <= s3_kind_q;
      s4_q.requested_direction <= s3_dir_q;
      s4_q.sample_ma           <= ma_prod[hog_pkg::MA_SHIFT +: 12];
    end
  end

endmodule

[rtl/core/hog_ctrl.sv]
module hog_ctrl #(
  parameter int unsigned AVG_LEN = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hog_pkg::scaled_t in_item_i,
  input  logic [10:0]      trip_threshold_ma_i,
  input  logic [15:0]      trip_ticks_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hog_pkg::result_t out_result_o
);

  localparam int unsigned IdxW   = $clog2(AVG_LEN + 1);
  // sum / AVG_LEN as (sum * RecipM) >> ShiftK, exact for 15-bit sums
  localparam int unsigned ShiftK = 15 + $clog2(AVG_LEN);
  localparam int unsigned RecipW = ShiftK + 1;
  localparam int unsigned ProdW  = 15 + RecipW;
  localparam logic [RecipW-1:0] RecipM =
    RecipW'(((64'd1 << ShiftK) + 64'(AVG_LEN) - 64'd1) / 64'(AVG_LEN));

  logic             out_valid_q;
  hog_pkg::result_t res_q;

  logic [1:0]      dir_q, dir_d;
  logic            fault_q, fault_d;
  logic [1:0]      lfr_q, lfr_d;
  logic [14:0]     sum_q, sum_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [10:0]     filt_q, filt_d;
  logic [15:0]     ot_q, ot_d;
  logic [1:0]      pin_d;

  logic             accept;
  logic [15:0]      sum_ext;
  logic [14:0]      sum_sat;
  logic [IdxW-1:0]  idx_inc;
  logic             wrap;
  logic [ProdW-1:0] div_prod;
  logic [15:0]      avg_p1;
  logic [10:0]      avg_sat;
  logic [10:0]      filt_eff;
  logic [15:0]      ot_inc;
  logic             over;
  logic             trip;
  logic [1:0]       req;
  logic             req_ok;

  assign in_ready_o   = !out_valid_q || out_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign out_result_o = res_q;

  // Averaging datapath
  assign sum_ext  = 16'(sum_q) + 16'(in_item_i.sample_ma);
  assign sum_sat  = (sum_ext > 16'(hog_pkg::SUM_MAX)) ? hog_pkg::SUM_MAX : sum_ext[14:0];
  assign idx_inc  = idx_q + IdxW'(1);
  assign wrap     = (idx_inc == IdxW'(AVG_LEN));
  assign div_prod = ProdW'(sum_sat) * ProdW'(RecipM);
  assign avg_p1   = 16'(div_prod[ShiftK +: 15]) + 16'd1;
  assign avg_sat  = (avg_p1 > 16'(hog_pkg::FILT_MAX)) ? hog_pkg::FILT_MAX : avg_p1[10:0];
  assign filt_eff = wrap ? avg_sat : filt_q;

  // Overcurrent persistence
  assign over   = filt_eff > trip_threshold_ma_i;
  assign ot_inc = (&ot_q) ? ot_q : ot_q + 16'd1;
  assign trip   = over && (ot_inc > trip_ticks_i);

  assign req    = in_item_i.requested_direction;
  assign req_ok = (req == hog_pkg::DIR_STOP) || (req == hog_pkg::DIR_FWD) ||
                  (req == hog_pkg::DIR_REV);

  always_comb begin
    dir_d   = dir_q;
    fault_d = fault_q;
    lfr_d   = lfr_q;
    sum_d   = sum_q;
    idx_d   = idx_q;
    filt_d  = filt_q;
    ot_d    = ot_q;
    if (in_item_i.kind == hog_pkg::KIND_TICK) begin
      if (wrap) begin
        sum_d  = '0;
        idx_d  = '0;
        filt_d = avg_sat;
      end else begin
        sum_d = sum_sat;
        idx_d = idx_inc;
      end
      ot_d = over ? ot_inc : 16'd0;
      if (trip) begin
        // stop request only bites before the latch is set
        if (!fault_q) dir_d = hog_pkg::DIR_STOP;
        fault_d = 1'b1;
      end
    end else if (req_ok) begin
      if (!fault_q) begin
        dir_d = req;
      end else begin
        if ((req == hog_pkg::DIR_FWD && lfr_q == hog_pkg::DIR_REV) ||
            (req == hog_pkg::DIR_REV && lfr_q == hog_pkg::DIR_FWD)) begin
          dir_d   = req;
          fault_d = 1'b0;
        end
        if (req == hog_pkg::DIR_FWD || req == hog_pkg::DIR_REV) lfr_d = req;
      end
    end
  end

  // Pins follow direction on ticks only
  always_comb begin
    pin_d = {res_q.drive_b, res_q.drive_a};
    if (in_item_i.kind == hog_pkg::KIND_TICK) begin
      case (dir_d)
        hog_pkg::DIR_FWD: pin_d = 2'b01;
        hog_pkg::DIR_REV: pin_d = 2'b10;
        default:          pin_d = 2'b00;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      dir_q       <= hog_pkg::DIR_STOP;
      fault_q     <= 1'b0;
      lfr_q       <= hog_pkg::DIR_STOP;
      sum_q       <= '0;
      idx_q       <= '0;
      filt_q      <= '0;
      ot_q        <= '0;
      res_q       <= '0;
    end else begin
      if (in_ready_o) out_valid_q <= in_valid_i;
      if (accept) begin
        dir_q               <= dir_d;
        fault_q             <= fault_d;
        lfr_q               <= lfr_d;
        sum_q               <= sum_d;
        idx_q               <= idx_d;
        filt_q              <= filt_d;
        ot_q                <= ot_d;
        res_q.drive_a       <= pin_d[0];
        res_q.drive_b       <= pin_d[1];
        res_q.direction_now <= dir_d;
        res_q.fault_flag    <= fault_d;
        res_q.filtered_ma   <= filt_d;
      end
    end
  end

endmodule

[rtl/core/hbridge_overcurrent_guard_core.sv]
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: kind; tdata: adc_sample, direction
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: drive_a, drive_b, direction, fault, mA
// cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// One item per cycle sustained while m_axis_tready is high; an accepted input item passes the
// input reg, adc*fullscale, /1023, *5/14, then state update into the result reg, where result tvalid rises.
// Each stage holds on a downstream stall and fills bubbles, so the input keeps
// taking items while a result waits, until all five registers hold an item.
// Async active-low reset clears control state
// and loads the config defaults (5000 mV, 250 mA, 500 ticks).
module hbridge_overcurrent_guard_core #(
  parameter int unsigned AVG_LEN = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [9:0] adc_sample, [11:10] requested_direction, rest 0
  input  logic        s_axis_tuser,  // [0] kind: 0 tick, 1 direction request
  // item out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [0] drive_a, [1] drive_b, [3:2] direction_now,
                                     // [4] fault_flag, [15:5] filtered_ma
  // config writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [12:0] fullscale_q;
  logic [10:0] threshold_q;
  logic [15:0] trip_ticks_q;

  hog_pkg::in_item_t in_item;
  hog_pkg::scaled_t  sc_item;
  hog_pkg::result_t  result;
  logic              sc_valid, sc_ready;

  // Registers are always writable; the sender keeps writes to idle periods
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fullscale_q  <= hog_pkg::FULLSCALE_RST;
      threshold_q  <= hog_pkg::THRESHOLD_RST;
      trip_ticks_q <= hog_pkg::TRIPTICKS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        hog_pkg::CFG_FULLSCALE: fullscale_q  <= cfg_data_i[12:0];
        hog_pkg::CFG_THRESHOLD: threshold_q  <= cfg_data_i[10:0];
        hog_pkg::CFG_TRIPTICKS: trip_ticks_q <= cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign in_item.kind                = s_axis_tuser;
  assign in_item.adc_sample          = s_axis_tdata[9:0];
  assign in_item.requested_direction = s_axis_tdata[11:10];

  // Sample to mA conversion pipe
  hog_scale u_scale (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_item_i      (in_item),
    .fullscale_mv_i (fullscale_q),
    .out_valid_o    (sc_valid),
    .out_ready_i    (sc_ready),
    .out_item_o     (sc_item)
  );

  // Averaging, trip logic, direction and pins
  hog_ctrl #(
    .AVG_LEN (AVG_LEN)
  ) u_ctrl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (sc_valid),
    .in_ready_o          (sc_ready),
    .in_item_i           (sc_item),
    .trip_threshold_ma_i (threshold_q),
    .trip_ticks_i        (trip_ticks_q),
    .out_valid_o         (m_axis_tvalid),
    .out_ready_i         (m_axis_tready),
    .out_result_o        (result)
  );

  assign m_axis_tdata = result;

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;

  localparam int unsigned SAMPLES      = 10;
  localparam logic [1:0]  DIR_BAD      = 2'd3;    // undefined direction code, ignored
  localparam logic [9:0]  ADC_MAX      = 10'h3FF;
  localparam int unsigned TICKS_MAX    = 65535;
  localparam int unsigned CHOKE_CYCLES = 150;     // long receiver hold-off

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [9:0] adc_sample, [11:10] requested_direction
  logic        s_axis_tuser;   // [0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [0] drive_a, [1] drive_b, [3:2] direction_now,
                               // [4] fault_flag, [15:5] filtered_ma
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  // Stimulus mode flags; burst and choke_req are shared by the sender and the receiver
  bit burst;       // no idling on either side
  bit choke_req;   // receiver to hold off for CHOKE_CYCLES
  bit offering;    // sender currently holds tvalid high
  int unsigned sent;
  int unsigned settings;

  hbridge_overcurrent_guard_core #(
    .AVG_LEN(SAMPLES)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Tracks the motor guard state and holds the bridge outputs it expects, oldest first
  class bridge_scoreboard;
    int unsigned      fullscale;
    int unsigned      threshold;
    int unsigned      trip_limit;
    logic [1:0]       direction;
    logic [1:0]       last_fault_dir;
    bit               fault;
    int unsigned      sum_ma;
    int unsigned      sample_idx;
    int unsigned      filtered;
    int unsigned      over_count;
    logic [1:0]       pins;        // {leg B, leg A}
    hog_pkg::result_t expected_q[$];
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      trips;
    int unsigned      clears;
    int unsigned      ignored;

    function new();
      fullscale      = hog_pkg::FULLSCALE_RST;
      threshold      = hog_pkg::THRESHOLD_RST;
      trip_limit     = hog_pkg::TRIPTICKS_RST;
      direction      = hog_pkg::DIR_STOP;
      last_fault_dir = hog_pkg::DIR_STOP;
      pins           = 2'b00;
    endfunction

    task report(string what);
      mismatches++;
      $display("tb: mismatch: %s", what);
    endtask

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        hog_pkg::CFG_FULLSCALE: fullscale  = val[12:0];
        hog_pkg::CFG_THRESHOLD: threshold  = val[10:0];
        hog_pkg::CFG_TRIPTICKS: trip_limit = val;
        default: ;
      endcase
    endfunction

    // Under a fault only a request opposite the last one made under the fault clears it
    function void steer(logic [1:0] want);
      if (!fault) begin
        direction = want;
        return;
      end
      if ((want == hog_pkg::DIR_FWD && last_fault_dir == hog_pkg::DIR_REV) ||
          (want == hog_pkg::DIR_REV && last_fault_dir == hog_pkg::DIR_FWD)) begin
        direction = want;
        fault     = 1'b0;
        clears++;
      end
      if (want == hog_pkg::DIR_FWD || want == hog_pkg::DIR_REV) last_fault_dir = want;
    endfunction

    function void take_sample(logic [9:0] adc);
      int unsigned mv;
      int unsigned avg;
      mv = (32'(adc) * fullscale) / 1023;
      sum_ma += (mv * 5) / 14;
      if (sum_ma > hog_pkg::SUM_MAX) sum_ma = hog_pkg::SUM_MAX;
      sample_idx++;
      if (sample_idx >= SAMPLES) begin
        avg        = sum_ma / SAMPLES + 1;
        filtered   = (avg > hog_pkg::FILT_MAX) ? hog_pkg::FILT_MAX : avg;
        sum_ma     = 0;
        sample_idx = 0;
      end
      if (filtered > threshold) begin
        if (over_count < TICKS_MAX) over_count++;
        if (over_count > trip_limit) begin
          if (!fault) trips++;
          steer(hog_pkg::DIR_STOP);
          fault = 1'b1;
        end
      end else begin
        over_count = 0;
      end
      pins = {direction == hog_pkg::DIR_REV, direction == hog_pkg::DIR_FWD};
    endfunction

    function void note_input(hog_pkg::in_item_t it);
      hog_pkg::result_t r;
      if (it.kind == hog_pkg::KIND_TICK) take_sample(it.adc_sample);
      else if (it.requested_direction == DIR_BAD) ignored++;
      else steer(it.requested_direction);
      r.drive_a       = pins[0];
      r.drive_b       = pins[1];
      r.direction_now = direction;
      r.fault_flag    = fault;
      r.filtered_ma   = filtered[10:0];
      expected_q.push_back(r);
    endfunction

    task check_result(logic [15:0] raw);
      hog_pkg::result_t got;
      hog_pkg::result_t want;
      got = raw;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %h with nothing expected", raw));
        return;
      end
      want = expected_q.pop_front();
      if (got.drive_a !== want.drive_a)
        report($sformatf("#%0d drive_a %b, expected %b", checked, got.drive_a, want.drive_a));
      if (got.drive_b !== want.drive_b)
        report($sformatf("#%0d drive_b %b, expected %b", checked, got.drive_b, want.drive_b));
      if (got.direction_now !== want.direction_now)
        report($sformatf("#%0d direction_now %0d, expected %0d", checked,
                         got.direction_now, want.direction_now));
      if (got.fault_flag !== want.fault_flag)
        report($sformatf("#%0d fault_flag %b, expected %b", checked,
                         got.fault_flag, want.fault_flag));
      if (got.filtered_ma !== want.filtered_ma)
        report($sformatf("#%0d filtered_ma %0d, expected %0d", checked,
                         got.filtered_ma, want.filtered_ma));
    endtask
  endclass

  bridge_scoreboard sb = new();

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (burst || choke_req) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic hog_pkg::in_item_t mk(logic kind, logic [9:0] adc, logic [1:0] dir);
    hog_pkg::in_item_t it;
    it.kind                = kind;
    it.adc_sample          = adc;
    it.requested_direction = dir;
    return it;
  endfunction

  // Ticks dominate; requests lean to forward/reverse so fault clears get exercised
  function automatic hog_pkg::in_item_t random_item();
    hog_pkg::in_item_t it;
    int r;
    it.kind = ($urandom_range(0, 99) < 78) ? hog_pkg::KIND_TICK : hog_pkg::KIND_REQ;
    r = $urandom_range(0, 99);
    if (r < 10)      it.adc_sample = 10'd0;
    else if (r < 20) it.adc_sample = ADC_MAX;
    else             it.adc_sample = 10'($urandom_range(0, 1023));
    r = $urandom_range(0, 99);
    if (r < 36)      it.requested_direction = hog_pkg::DIR_FWD;
    else if (r < 72) it.requested_direction = hog_pkg::DIR_REV;
    else if (r < 90) it.requested_direction = hog_pkg::DIR_STOP;
    else             it.requested_direction = DIR_BAD;
    return it;
  endfunction

  task automatic send_item(hog_pkg::in_item_t it);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= {4'b0000, it.requested_direction, it.adc_sample};
    offering = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(it);
    sent++;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Every item yields a result, so an empty store means the pipeline is empty
  task automatic drain();
    if (offering) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
    end
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(int unsigned fs, int unsigned thr, int unsigned trip);
    drain();
    write_reg(hog_pkg::CFG_FULLSCALE, 16'(fs));
    write_reg(hog_pkg::CFG_THRESHOLD, 16'(thr));
    write_reg(hog_pkg::CFG_TRIPTICKS, 16'(trip));
    settings++;
  endtask

  task automatic run_random(int unsigned n, bit choke);
    for (int unsigned i = 0; i < n; i++) begin
      if (choke && i == n / 4) choke_req = 1'b1;
      send_item(random_item());
    end
  endtask

  // Receiver: checks results and idles tready, with one long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned choke_left;
    hold_left     = 0;
    choke_left    = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (choke_req && choke_left == 0) choke_left = CHOKE_CYCLES;
      if (choke_left > 0) begin
        choke_left--;
        m_axis_tready <= 1'b0;
        if (choke_left == 0) choke_req = 1'b0;
      end else if (burst) begin
        m_axis_tready <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 99) < 25)
          hold_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                   : $urandom_range(8, 40);
      end
    end
  end

  initial begin
    logic [9:0] warm_adc [10];
    warm_adc = '{10'd0, ADC_MAX, ADC_MAX, 10'd1, 10'd512, 10'd1022, ADC_MAX, 10'd0,
                 ADC_MAX, 10'd341};
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = hog_pkg::KIND_TICK;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = hog_pkg::CFG_FULLSCALE;
    cfg_data_i    = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: every direction, the bad code, one full averaging block
    send_item(mk(hog_pkg::KIND_REQ, ADC_MAX, hog_pkg::DIR_FWD));
    send_item(mk(hog_pkg::KIND_REQ, 10'd0, hog_pkg::DIR_REV));
    send_item(mk(hog_pkg::KIND_REQ, 10'd0, hog_pkg::DIR_STOP));
    send_item(mk(hog_pkg::KIND_REQ, 10'd0, DIR_BAD));
    send_item(mk(hog_pkg::KIND_REQ, 10'd0, hog_pkg::DIR_FWD));
    foreach (warm_adc[i]) send_item(mk(hog_pkg::KIND_TICK, warm_adc[i], DIR_BAD));

    // Instant trip, then the clear rules: same-side request, stop and bad code do nothing
    set_config(1000, 0, 0);
    send_item(mk(hog_pkg::KIND_TICK, 10'd0, hog_pkg::DIR_FWD));
    send_item(mk(hog_pkg::KIND_REQ, 10'd0, hog_pkg::DIR_FWD));
    send_item(mk(hog_pkg::KIND_REQ, 10'd0, hog_pkg::DIR_STOP));
    send_item(mk(hog_pkg::KIND_REQ, 10'd0, DIR_BAD));
    send_item(mk(hog_pkg::KIND_REQ, 10'd0, hog_pkg::DIR_REV));
    send_item(mk(hog_pkg::KIND_TICK, ADC_MAX, hog_pkg::DIR_STOP));
    send_item(mk(hog_pkg::KIND_REQ, 10'd0, hog_pkg::DIR_REV));
    send_item(mk(hog_pkg::KIND_REQ, 10'd0, hog_pkg::DIR_FWD));

    // Random phases across the register extremes
    set_config(5000, 0, 0);
    run_random(100, 1'b1);
    set_config(1000, 0, TICKS_MAX);        // counts over but can never trip
    burst = 1'b1;
    run_random(80, 1'b0);
    burst = 1'b0;
    set_config(3300, $urandom_range(100, 600), $urandom_range(0, 30));
    run_random(200, 1'b0);
    set_config(5000, 2047, 0);             // threshold out of reach
    run_random(60, 1'b0);
    set_config($urandom_range(1000, 5000), $urandom_range(0, 1500), $urandom_range(0, 200));
    run_random(170, 1'b1);

    drain();
    repeat (12) @(posedge clk_i);
    $display("tb: %0d items sent, %0d results checked under %0d register settings",
             sent, sb.checked, settings + 1);
    $display("tb: %0d trips, %0d fault clears, %0d bad-code requests, %0d mismatches",
             sb.trips, sb.clears, sb.ignored, sb.mismatches);
    if (sb.mismatches == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: timeout with %0d results outstanding", sb.expected_q.size());
    $display("tb: FAIL");
    $finish;
  end

endmodule
